>>> hdl/qtb_pkg.sv
// Shared types and constants of the quad tile binning unit.
package qtb_pkg;

    localparam int COORD_W  = 16;
    localparam int HANDLE_W = 16;
    localparam int SIZE_W   = 13;
    localparam int CNT_W    = 12;
    localparam int TILE_W   = 6;
    localparam int SLOT_W   = 11;
    localparam int STATUS_W = 2;
    localparam int REG_IDX_W = 2;

    // Operation codes of an input word.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_PLACED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd2;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    typedef logic signed [COORD_W-1:0] t_coord;

    // A classified command as it travels from the front part to the back part.
    typedef struct packed {
        logic                cmd;
        logic [HANDLE_W-1:0] handle;
        t_coord              min_x;
        t_coord              max_x;
        t_coord              min_y;
        t_coord              max_y;
    } t_bin_cmd;

endpackage

>>> hdl/qtb_front.sv
// Front part: accepts input words, forms the bounding box and queues the command.
module qtb_front
    import qtb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_cmd,
    input  logic [HANDLE_W-1:0] i_cmd_handle,
    input  t_coord              i_ax,
    input  t_coord              i_ay,
    input  t_coord              i_bx,
    input  t_coord              i_by_coord,
    input  t_coord              i_cx_coord,
    input  t_coord              i_cy_coord,
    input  t_coord              i_dx_coord,
    input  t_coord              i_dy_coord,
    output logic                o_cmd_valid,
    output t_bin_cmd            o_cmd,
    input  logic                i_cmd_pop
);

    t_bin_cmd   r_fifo [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;
    logic [1:0] n_count;

    t_bin_cmd w_entry;
    t_coord   w_minx_ab, w_minx_cd, w_maxx_ab, w_maxx_cd;
    t_coord   w_miny_ab, w_miny_cd, w_maxy_ab, w_maxy_cd;
    logic     w_push;

    // Two-level min/max tree over the four corners.
    always_comb begin
        w_minx_ab = (i_ax < i_bx) ? i_ax : i_bx;
        w_minx_cd = (i_cx_coord < i_dx_coord) ? i_cx_coord : i_dx_coord;
        w_maxx_ab = (i_ax > i_bx) ? i_ax : i_bx;
        w_maxx_cd = (i_cx_coord > i_dx_coord) ? i_cx_coord : i_dx_coord;
        w_miny_ab = (i_ay < i_by_coord) ? i_ay : i_by_coord;
        w_miny_cd = (i_cy_coord < i_dy_coord) ? i_cy_coord : i_dy_coord;
        w_maxy_ab = (i_ay > i_by_coord) ? i_ay : i_by_coord;
        w_maxy_cd = (i_cy_coord > i_dy_coord) ? i_cy_coord : i_dy_coord;

        w_entry.cmd    = i_cmd;
        w_entry.handle = i_cmd_handle;
        w_entry.min_x  = (w_minx_ab < w_minx_cd) ? w_minx_ab : w_minx_cd;
        w_entry.max_x  = (w_maxx_ab > w_maxx_cd) ? w_maxx_ab : w_maxx_cd;
        w_entry.min_y  = (w_miny_ab < w_miny_cd) ? w_miny_ab : w_miny_cd;
        w_entry.max_y  = (w_maxy_ab > w_maxy_cd) ? w_maxy_ab : w_maxy_cd;
    end

    assign o_in_stall  = (r_count == 2'd2);
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_fifo[r_rp];

    always_comb begin
        n_count = r_count;
        if (w_push && !(i_cmd_pop && o_cmd_valid)) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_cmd_pop && o_cmd_valid) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_cmd_pop && o_cmd_valid) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp] <= w_entry;
        end
    end

endmodule

>>> hdl/qtb_back.sv
// Back part: scans the tiles for one command, keeps the tile counts and drives results.
module qtb_back
    import qtb_pkg::*;
#(
    parameter int TILES_X       = 4,
    parameter int TILES_Y       = 4,
    parameter int TILE_CAPACITY = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [SIZE_W-1:0]   i_tile_w,
    input  logic [SIZE_W-1:0]   i_tile_h,
    input  logic                i_cmd_valid,
    input  t_bin_cmd            i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [TILE_W-1:0]   o_tile_index,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [HANDLE_W-1:0] o_handle_out,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_last
);

    localparam int NT = TILES_X * TILES_Y;
    localparam int AW = (NT > 1) ? $clog2(NT) : 1;
    localparam int CW = (TILES_X > 1) ? $clog2(TILES_X) : 1;
    localparam int RW = (TILES_Y > 1) ? $clog2(TILES_Y) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                r_state, n_state;
    t_bin_cmd            r_item, n_item;
    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [AW-1:0]       r_tile, n_tile;
    logic [SIZE_W-1:0]   r_x0, n_x0, r_y0, n_y0;
    logic                r_scan_done, n_scan_done;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_pend_tile, n_pend_tile;

    logic                r_out_vld, n_out_vld;
    logic [TILE_W-1:0]   r_out_tile, n_out_tile;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic [HANDLE_W-1:0] r_out_handle, n_out_handle;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic                r_out_last, n_out_last;

    // Tile count store; an entry whose valid bit is clear reads as zero.
    logic [CNT_W-1:0]    r_cnt_mem [NT];
    logic [NT-1:0]       r_cnt_vld;
    logic [CNT_W-1:0]    r_rd_data;
    logic                r_rd_vld;

    logic                w_mem_we, w_mem_re, w_clr_all;
    logic [AW-1:0]       w_mem_wa, w_mem_ra;
    logic [CNT_W-1:0]    w_mem_wd;

    logic                w_out_free, w_hit, w_adv, w_last_tile;
    logic [CNT_W-1:0]    w_pend_cnt;
    logic                w_pend_full;
    logic signed [COORD_W:0] w_x0, w_x1, w_y0, w_y1;

    assign w_out_free = !r_out_vld || !i_out_stall;

    // Inclusive overlap test of the current tile against the bounding box.
    always_comb begin
        w_x0  = $signed({4'b0, r_x0});
        w_y0  = $signed({4'b0, r_y0});
        w_x1  = $signed({3'b0, {1'b0, r_x0} + {1'b0, i_tile_w}});
        w_y1  = $signed({3'b0, {1'b0, r_y0} + {1'b0, i_tile_h}});
        w_hit = !((w_x0 > $signed({r_item.max_x[COORD_W-1], r_item.max_x}))
               || (w_x1 < $signed({r_item.min_x[COORD_W-1], r_item.min_x}))
               || (w_y1 < $signed({r_item.min_y[COORD_W-1], r_item.min_y}))
               || (w_y0 > $signed({r_item.max_y[COORD_W-1], r_item.max_y})));
    end

    assign w_pend_cnt  = r_rd_vld ? r_rd_data : '0;
    assign w_pend_full = (w_pend_cnt >= CNT_W'(TILE_CAPACITY));
    assign w_last_tile = (r_col == CW'(TILES_X - 1)) && (r_row == RW'(TILES_Y - 1));

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_col        = r_col;
        n_row        = r_row;
        n_tile       = r_tile;
        n_x0         = r_x0;
        n_y0         = r_y0;
        n_scan_done  = r_scan_done;
        n_pend       = r_pend;
        n_pend_tile  = r_pend_tile;
        n_out_vld    = r_out_vld && i_out_stall;
        n_out_tile   = r_out_tile;
        n_out_slot   = r_out_slot;
        n_out_handle = r_out_handle;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        o_cmd_pop    = 1'b0;
        w_clr_all    = 1'b0;
        w_mem_re     = 1'b0;
        w_mem_ra     = r_tile;
        w_mem_we     = 1'b0;
        w_mem_wa     = r_pend_tile;
        w_mem_wd     = w_pend_cnt + CNT_W'(1);
        w_adv        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.cmd == CMD_CLEAR) begin
                        w_clr_all    = 1'b1;
                        n_out_vld    = 1'b1;
                        n_out_tile   = '0;
                        n_out_slot   = '0;
                        n_out_handle = '0;
                        n_out_status = STATUS_NONE;
                        n_out_last   = 1'b1;
                    end else begin
                        n_item      = i_cmd;
                        n_col       = '0;
                        n_row       = '0;
                        n_tile      = '0;
                        n_x0        = '0;
                        n_y0        = '0;
                        n_scan_done = 1'b0;
                        n_pend      = 1'b0;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!r_scan_done) begin
                    if (!w_hit) begin
                        w_adv = 1'b1;
                    end else if (!r_pend || w_out_free) begin
                        // A new hit proves the held result is not the last one.
                        if (r_pend) begin
                            n_out_vld    = 1'b1;
                            n_out_tile   = TILE_W'(r_pend_tile);
                            n_out_slot   = w_pend_full ? '0 : w_pend_cnt[SLOT_W-1:0];
                            n_out_handle = r_item.handle;
                            n_out_status = w_pend_full ? STATUS_FULL : STATUS_PLACED;
                            n_out_last   = 1'b0;
                            w_mem_we     = !w_pend_full;
                        end
                        w_mem_re    = 1'b1;
                        n_pend      = 1'b1;
                        n_pend_tile = r_tile;
                        w_adv       = 1'b1;
                    end
                end else if (w_out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_handle = r_item.handle;
                    n_out_last   = 1'b1;
                    if (r_pend) begin
                        n_out_tile   = TILE_W'(r_pend_tile);
                        n_out_slot   = w_pend_full ? '0 : w_pend_cnt[SLOT_W-1:0];
                        n_out_status = w_pend_full ? STATUS_FULL : STATUS_PLACED;
                        w_mem_we     = !w_pend_full;
                    end else begin
                        n_out_tile   = '0;
                        n_out_slot   = '0;
                        n_out_status = STATUS_NONE;
                    end
                    n_pend  = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Column-major walk: rows inside, columns outside.
        if (w_adv) begin
            if (w_last_tile) begin
                n_scan_done = 1'b1;
            end else if (r_row == RW'(TILES_Y - 1)) begin
                n_row  = '0;
                n_y0   = '0;
                n_col  = r_col + CW'(1);
                n_x0   = r_x0 + i_tile_w;
                n_tile = AW'(r_col) + AW'(1);
            end else begin
                n_row  = r_row + RW'(1);
                n_y0   = r_y0 + i_tile_h;
                n_tile = r_tile + AW'(TILES_X);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan_done <= 1'b0;
            r_pend      <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan_done <= n_scan_done;
            r_pend      <= n_pend;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_col        <= n_col;
        r_row        <= n_row;
        r_tile       <= n_tile;
        r_x0         <= n_x0;
        r_y0         <= n_y0;
        r_pend_tile  <= n_pend_tile;
        r_out_tile   <= n_out_tile;
        r_out_slot   <= n_out_slot;
        r_out_handle <= n_out_handle;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr_all) begin
            r_cnt_vld <= '0;
        end else if (w_mem_we) begin
            r_cnt_vld[w_mem_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_cnt_mem[w_mem_wa] <= w_mem_wd;
        end
        if (w_mem_re) begin
            r_rd_data <= r_cnt_mem[w_mem_ra];
            r_rd_vld  <= r_cnt_vld[w_mem_ra];
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_tile_index = r_out_tile;
    assign o_slot       = r_out_slot;
    assign o_handle_out = r_out_handle;
    assign o_status     = r_out_status;
    assign o_last       = r_out_last;

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_we && w_mem_re) |-> (w_mem_wa != w_mem_ra))
        else $error("count store written and read at the same tile");

    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == ST_SCAN))
        else $error("held result outside of a tile scan");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status == STATUS_PLACED)
        |-> ({1'b0, r_out_slot} < CNT_W'(TILE_CAPACITY)))
        else $error("placed slot beyond tile capacity");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && i_cmd.cmd == CMD_CLEAR)
        |=> (r_out_vld && r_out_status == STATUS_NONE && r_out_last && r_cnt_vld == '0))
        else $error("clear did not produce its result");

endmodule

>>> hdl/quad_tile_binning_unit.sv
// Top level of the quad tile binning unit: configuration registers and the two parts.
//
// The unit bins quad draw commands into a TILES_X by TILES_Y grid of screen tiles.
// Each input word is either an add, carrying four signed corners and a 16-bit command
// handle, or a clear, which zeroes every tile count. A front part forms the bounding box
// of an add and places the command in a two-entry queue, so new words keep being taken
// while the back part works. The back part walks the tiles column by column, rows inside
// each column, testing one tile per cycle with inclusive edges while results are not
// stalled; every overlapping tile yields one result word with the tile index, the next
// free slot of that tile and the handle, and its count goes up by one. A tile whose
// count has reached TILE_CAPACITY reports status full with slot zero and keeps its
// count. An add that touches no tile gives a single status none word with the handle;
// a clear gives a single status none word with zero fields. The final word of every
// command has last set. The back part takes no new command until the tile walk of an
// add is over; a clear needs no walk. Counts live in a small memory with one valid bit
// per tile, so reset and clear take effect at once and no clearing pass is needed. Tile
// width and height are the screen size registers divided by the grid size, computed when
// a register is written; writes to an index past the two registers are ignored, and the
// configuration port is always ready. Configuration is meant to change only while the
// unit is idle.
module quad_tile_binning_unit
    import qtb_pkg::*;
#(
    parameter int TILES_X       = 4,
    parameter int TILES_Y       = 4,
    parameter int TILE_CAPACITY = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_cmd,
    input  logic [HANDLE_W-1:0]  i_cmd_handle,
    input  t_coord               i_ax,
    input  t_coord               i_ay,
    input  t_coord               i_bx,
    input  t_coord               i_by_coord,
    input  t_coord               i_cx_coord,
    input  t_coord               i_cy_coord,
    input  t_coord               i_dx_coord,
    input  t_coord               i_dy_coord,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [TILE_W-1:0]    o_tile_index,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [HANDLE_W-1:0]  o_handle_out,
    output logic [STATUS_W-1:0]  o_status,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [REG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    // The grid size need not be a power of two, so the division by it is a multiply by
    // its rounded-up reciprocal followed by a shift. Sixteen fraction bits keep the
    // quotient exact for every 13-bit screen size and every grid size up to eight.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SIZE_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_X =
        RECIP_W'(((1 << RECIP_SHIFT) + TILES_X - 1) / TILES_X);
    localparam logic [RECIP_W-1:0] RECIP_Y =
        RECIP_W'(((1 << RECIP_SHIFT) + TILES_Y - 1) / TILES_Y);

    // Tile sizes derived from the screen size registers at write time.
    logic [SIZE_W-1:0] r_tile_w;
    logic [SIZE_W-1:0] r_tile_h;

    logic [PROD_W-1:0] w_tile_w_prod;
    logic [PROD_W-1:0] w_tile_h_prod;

    logic     w_cmd_valid;
    logic     w_cmd_pop;
    t_bin_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    assign w_tile_w_prod = PROD_W'(i_cfg_data) * PROD_W'(RECIP_X);
    assign w_tile_h_prod = PROD_W'(i_cfg_data) * PROD_W'(RECIP_Y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_w <= SIZE_W'(320 / TILES_X);
            r_tile_h <= SIZE_W'(224 / TILES_Y);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_SCREEN_WIDTH) begin
                r_tile_w <= w_tile_w_prod[RECIP_SHIFT +: SIZE_W];
            end else if (i_cfg_index == REG_SCREEN_HEIGHT) begin
                r_tile_h <= w_tile_h_prod[RECIP_SHIFT +: SIZE_W];
            end
        end
    end

    qtb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_cmd_handle (i_cmd_handle),
        .i_ax         (i_ax),
        .i_ay         (i_ay),
        .i_bx         (i_bx),
        .i_by_coord   (i_by_coord),
        .i_cx_coord   (i_cx_coord),
        .i_cy_coord   (i_cy_coord),
        .i_dx_coord   (i_dx_coord),
        .i_dy_coord   (i_dy_coord),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_pop    (w_cmd_pop)
    );

    qtb_back #(
        .TILES_X       (TILES_X),
        .TILES_Y       (TILES_Y),
        .TILE_CAPACITY (TILE_CAPACITY)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tile_w     (r_tile_w),
        .i_tile_h     (r_tile_h),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_pop    (w_cmd_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_tile_index (o_tile_index),
        .o_slot       (o_slot),
        .o_handle_out (o_handle_out),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule

>>> bench/quad_tile_binning_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the quad tile binning unit, built around a tile binning predictor.
module quad_tile_binning_unit_test;
    import qtb_pkg::*;

    // The grid and capacity match the defaults of the unit and are passed to it explicitly.
    localparam int TILES_X       = 4;
    localparam int TILES_Y       = 4;
    localparam int TILE_CAPACITY = 2048;
    localparam int NUM_TILES     = TILES_X * TILES_Y;

    // Screen size registers come out of reset with these values.
    localparam int RESET_WIDTH  = 320;
    localparam int RESET_HEIGHT = 224;
    localparam int SIZE_MAX     = (1 << SIZE_W) - 1;

    // The register port decodes two index bits, but only two registers exist. The
    // remaining indexes must be ignored, so they get names here for the spare writes.
    localparam logic [REG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // An add, a stall burst and a gap all end well inside QUIET_LIMIT. So that long a
    // stretch without any handshake can only mean the unit has hung.
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 40;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_WORDS = 15;
    localparam int NUM_PHASES   = 7;

    // One input word: the operation, the handle and four corners.
    typedef struct packed {
        logic                cmd;
        logic [HANDLE_W-1:0] handle;
        t_coord              a_x;
        t_coord              a_y;
        t_coord              b_x;
        t_coord              b_y;
        t_coord              c_x;
        t_coord              c_y;
        t_coord              d_x;
        t_coord              d_y;
    } t_quad_word;

    // One result word, in the order of the output ports.
    typedef struct packed {
        logic [TILE_W-1:0]   tile;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] handle;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_bin_result;

    // A row of the directed table. When fixed is set, the single result word is typed into
    // the row. Otherwise the predictor supplies the expected words.
    typedef struct packed {
        t_quad_word  word;
        logic        fixed;
        t_bin_result result;
    } t_directed_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_quad_word           drive_word;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [TILE_W-1:0]    o_tile_index;
    logic [SLOT_W-1:0]    o_slot;
    logic [HANDLE_W-1:0]  o_handle_out;
    logic [STATUS_W-1:0]  o_status;
    logic                 o_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [REG_IDX_W-1:0] i_cfg_index;
    logic [SIZE_W-1:0]    i_cfg_data;

    // These travel alongside the payload. They are driven with the payload so that the
    // monitor sees them at the same edge as the word they belong to.
    logic        row_fixed;
    t_bin_result row_result;

    // The predictor keeps its own copy of the registers and of the tile counts.
    int                 scr_width;
    int                 scr_height;
    logic [CNT_W-1:0]   tile_fill [NUM_TILES];
    t_bin_result        fresh_bins [$];
    t_bin_result        expected_bins [$];

    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    bit          idle_on;

    quad_tile_binning_unit #(
        .TILES_X       (TILES_X),
        .TILES_Y       (TILES_Y),
        .TILE_CAPACITY (TILE_CAPACITY)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (drive_word.cmd),
        .i_cmd_handle (drive_word.handle),
        .i_ax         (drive_word.a_x),
        .i_ay         (drive_word.a_y),
        .i_bx         (drive_word.b_x),
        .i_by_coord   (drive_word.b_y),
        .i_cx_coord   (drive_word.c_x),
        .i_cy_coord   (drive_word.c_y),
        .i_dx_coord   (drive_word.d_x),
        .i_dy_coord   (drive_word.d_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_tile_index (o_tile_index),
        .o_slot       (o_slot),
        .o_handle_out (o_handle_out),
        .o_status     (o_status),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Builds a word from plain integers. Each coordinate keeps only its low 16 bits.
    function automatic t_quad_word quad(input logic cmd, input int handle,
                                        input int ax, input int ay, input int bx, input int by_,
                                        input int cx, input int cy, input int dx, input int dy);
        t_quad_word w;
        w.cmd    = cmd;
        w.handle = handle[HANDLE_W-1:0];
        w.a_x    = ax[COORD_W-1:0];
        w.a_y    = ay[COORD_W-1:0];
        w.b_x    = bx[COORD_W-1:0];
        w.b_y    = by_[COORD_W-1:0];
        w.c_x    = cx[COORD_W-1:0];
        w.c_y    = cy[COORD_W-1:0];
        w.d_x    = dx[COORD_W-1:0];
        w.d_y    = dy[COORD_W-1:0];
        return w;
    endfunction

    // Builds the lone result word of a clear, of an add that touches nothing, or of an
    // add that lands only in tile zero while that tile is empty.
    function automatic t_bin_result single_result(input logic [HANDLE_W-1:0] handle,
                                                  input logic [STATUS_W-1:0] status);
        t_bin_result r;
        r.tile   = '0;
        r.slot   = '0;
        r.handle = handle;
        r.status = status;
        r.last   = 1'b1;
        return r;
    endfunction

    // Tile binning predictor. It takes the bounding box of the four corners, then walks the
    // columns and, inside each column, the rows. Tile edges are inclusive on both sides.
    // The result words of one accepted word are left in fresh_bins.
    task automatic bin_quad(input t_quad_word w);
        int xs [4];
        int ys [4];
        int min_x, max_x, min_y, max_y;
        int tw, th, x0, y0, col, row, k;
        logic [TILE_W-1:0] t;
        t_bin_result r;
        fresh_bins.delete();
        if (w.cmd == CMD_CLEAR) begin
            for (k = 0; k < NUM_TILES; k++) tile_fill[k] = '0;
            fresh_bins.push_back(single_result('0, STATUS_NONE));
        end else begin
            xs[0] = w.a_x; ys[0] = w.a_y;
            xs[1] = w.b_x; ys[1] = w.b_y;
            xs[2] = w.c_x; ys[2] = w.c_y;
            xs[3] = w.d_x; ys[3] = w.d_y;
            min_x = xs[0]; max_x = xs[0];
            min_y = ys[0]; max_y = ys[0];
            for (k = 1; k < 4; k++) begin
                if (xs[k] < min_x) min_x = xs[k];
                if (xs[k] > max_x) max_x = xs[k];
                if (ys[k] < min_y) min_y = ys[k];
                if (ys[k] > max_y) max_y = ys[k];
            end
            // Tile sizes are truncated. A zero size makes every column, or every row,
            // collapse onto the same spot.
            tw = scr_width / TILES_X;
            th = scr_height / TILES_Y;
            for (col = 0; col < TILES_X; col++) begin
                x0 = col * tw;
                for (row = 0; row < TILES_Y; row++) begin
                    y0 = row * th;
                    if (!(x0 > max_x || x0 + tw < min_x || y0 + th < min_y || y0 > max_y)) begin
                        t = TILE_W'(col + row * TILES_X);
                        r.tile   = t;
                        r.handle = w.handle;
                        r.last   = 1'b0;
                        if (tile_fill[t] < TILE_CAPACITY) begin
                            r.slot   = SLOT_W'(tile_fill[t]);
                            r.status = STATUS_PLACED;
                            tile_fill[t] = tile_fill[t] + 1'b1;
                        end else begin
                            // A full tile drops the command and keeps its count.
                            r.slot   = '0;
                            r.status = STATUS_FULL;
                        end
                        fresh_bins.push_back(r);
                    end
                end
            end
            if (fresh_bins.size() == 0)
                fresh_bins.push_back(single_result(w.handle, STATUS_NONE));
            else
                fresh_bins[fresh_bins.size() - 1].last = 1'b1;
        end
    endtask

    // Makes one random word for the current screen size. Most words are well formed and
    // land on or near the screen, some sit on or one off tile edges, and the rest are clears
    // or corners taken from the whole coordinate range.
    function automatic t_quad_word random_quad();
        int xs [4];
        int ys [4];
        int pick, k, tw, th, base_x, base_y, span_x, span_y;
        pick   = $urandom_range(0, 99);
        tw     = scr_width / TILES_X;
        th     = scr_height / TILES_Y;
        base_x = int'($urandom_range(0, scr_width + 40)) - 20;
        base_y = int'($urandom_range(0, scr_height + 40)) - 20;
        span_x = $urandom_range(0, scr_width / 3 + 4);
        span_y = $urandom_range(0, scr_height / 3 + 4);
        for (k = 0; k < 4; k++) begin
            if (pick < 22) begin
                xs[k] = $urandom;
                ys[k] = $urandom;
            end else if (pick < 40) begin
                xs[k] = int'($urandom_range(0, TILES_X)) * tw + int'($urandom_range(0, 2)) - 1;
                ys[k] = int'($urandom_range(0, TILES_Y)) * th + int'($urandom_range(0, 2)) - 1;
            end else begin
                xs[k] = base_x + int'($urandom_range(0, span_x));
                ys[k] = base_y + int'($urandom_range(0, span_y));
            end
        end
        return quad((pick < 8) ? CMD_CLEAR : CMD_ADD, $urandom_range(0, 65535),
                    xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], xs[3], ys[3]);
    endfunction

    // Presents one word and holds it until the unit takes it. When idling is on, a random
    // gap may come first. Valid stays high from word to word when there is no gap.
    task automatic send_word(input t_quad_word w, input logic fixed, input t_bin_result res);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        drive_word <= w;
        row_fixed  <= fixed;
        row_result <= res;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Writes one register. The first wait keeps this write's valid away from the step
    // in which the previous write lowered it.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int data);
        @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= data[SIZE_W-1:0];
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every expected result word has come out. Registers may change only then.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_bins.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The receiver stalls in random bursts. The stall always drops again between
    // two bursts.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // The monitor samples all three handshakes at each rising edge. Register writes update
    // the predictor's copy of the registers. Every accepted word is run through the
    // predictor. Every accepted result word is checked against the oldest expected word.
    always @(posedge i_clk) begin
        t_bin_result got;
        t_bin_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_SCREEN_WIDTH)
                    scr_width = i_cfg_data;
                else if (i_cfg_index == REG_SCREEN_HEIGHT)
                    scr_height = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                bin_quad(drive_word);
                if (row_fixed)
                    expected_bins.push_back(row_result);
                else
                    foreach (fresh_bins[n]) expected_bins.push_back(fresh_bins[n]);
            end
            if (o_out_valid && !i_out_stall) begin
                got = {o_tile_index, o_slot, o_handle_out, o_status, o_last};
                if (expected_bins.size() == 0) begin
                    $display("%0t: result word with nothing expected: tile %0d slot %0d handle %h status %0d last %0b",
                             $time, got.tile, got.slot, got.handle, got.status, got.last);
                    mismatch_count++;
                end else begin
                    want = expected_bins.pop_front();
                    if (got.tile !== want.tile) begin
                        $display("%0t: tile_index expected %0d, got %0d", $time, want.tile, got.tile);
                        mismatch_count++;
                    end
                    if (got.slot !== want.slot) begin
                        $display("%0t: slot expected %0d, got %0d", $time, want.slot, got.slot);
                        mismatch_count++;
                    end
                    if (got.handle !== want.handle) begin
                        $display("%0t: handle_out expected %h, got %h", $time, want.handle, got.handle);
                        mismatch_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                        mismatch_count++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last expected %0b, got %0b", $time, want.last, got.last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // The watchdog ends the run when no handshake of any kind happens for too long. That
    // covers a hung unit, and also a result word that never arrives.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("quad_tile_binning_unit_test NOT OK");
            $finish;
        end
    end

    initial begin
        t_directed_row dir_rows [$];
        int phase_w [NUM_PHASES];
        int phase_h [NUM_PHASES];
        int k, p;

        // Every input has a known value from time zero. The predictor starts in its
        // reset state.
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        drive_word     = '0;
        row_fixed      = 1'b0;
        row_result     = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        scr_width      = RESET_WIDTH;
        scr_height     = RESET_HEIGHT;
        mismatch_count = 0;
        quiet_cycles   = 0;
        idle_on        = 1'b1;
        for (k = 0; k < NUM_TILES; k++) tile_fill[k] = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, run with the reset screen of 320 by 224. That gives tiles of
        // 80 by 56 pixels.
        // A small box inside tile zero lands in slot zero of that tile.
        dir_rows.push_back('{quad(CMD_ADD, 'h0001, 5, 5, 10, 5, 10, 10, 5, 10),
                             1'b1, single_result('h0001, STATUS_PLACED)});
        // Corners at the extremes of the coordinate range, far off screen, place nothing.
        dir_rows.push_back('{quad(CMD_ADD, 'hFFFF, -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768, -32768),
                             1'b1, single_result('hFFFF, STATUS_NONE)});
        dir_rows.push_back('{quad(CMD_ADD, 'h0000, 32767, 32767, 32767, 32767,
                                  32767, 32767, 32767, 32767),
                             1'b1, single_result('h0000, STATUS_NONE)});
        // One pixel past the right edge of the screen misses every tile.
        dir_rows.push_back('{quad(CMD_ADD, 'h0321, 321, 0, 321, 0, 321, 0, 321, 0),
                             1'b1, single_result('h0321, STATUS_NONE)});
        // The box spanning the whole coordinate range covers all sixteen tiles.
        dir_rows.push_back('{quad(CMD_ADD, 'h5A5A, -32768, -32768, 32767, -32768,
                                  32767, 32767, -32768, 32767), 1'b0, '0});
        // A point on an inner tile corner touches four tiles, because edges are inclusive.
        dir_rows.push_back('{quad(CMD_ADD, 'h1234, 80, 56, 80, 56, 80, 56, 80, 56), 1'b0, '0});
        // The bottom right screen corner is covered by the last tile.
        dir_rows.push_back('{quad(CMD_ADD, 'h4321, 320, 224, 320, 224, 320, 224, 320, 224),
                             1'b0, '0});
        // A box that ends exactly at the origin. Its corners are listed in shuffled order.
        dir_rows.push_back('{quad(CMD_ADD, 'h00FF, 0, -100, -100, 0, 0, 0, -100, -100),
                             1'b0, '0});
        // A clear ignores its handle and corners and reports zero fields.
        dir_rows.push_back('{quad(CMD_CLEAR, 'h7777, 1, 2, 3, 4, 5, 6, 7, 8),
                             1'b1, single_result('0, STATUS_NONE)});
        // The box takes its minimum from one corner and its maximum from another; the other two corners lie inside it.
        dir_rows.push_back('{quad(CMD_ADD, 'hABCD, 100, 100, 150, 60, 200, 200, 10, 30),
                             1'b0, '0});
        // A vertical line on a column edge touches both columns, in every row.
        dir_rows.push_back('{quad(CMD_ADD, 'h8000, 160, 0, 160, 224, 160, 0, 160, 224),
                             1'b0, '0});
        // A line just left of the screen misses everything.
        dir_rows.push_back('{quad(CMD_ADD, 'h0F0F, -1, -5, -1, 300, -1, -5, -1, 300),
                             1'b1, single_result('h0F0F, STATUS_NONE)});
        dir_rows.push_back('{quad(CMD_CLEAR, 'h0000, 0, 0, 0, 0, 0, 0, 0, 0),
                             1'b1, single_result('0, STATUS_NONE)});
        // After a clear, tile zero starts again at slot zero.
        dir_rows.push_back('{quad(CMD_ADD, 'h2468, 5, 5, 10, 5, 10, 10, 5, 10),
                             1'b1, single_result('h2468, STATUS_PLACED)});
        dir_rows.push_back('{quad(CMD_ADD, 'h1357, 241, 169, 250, 169, 250, 180, 241, 180),
                             1'b0, '0});
        foreach (dir_rows[n]) send_word(dir_rows[n].word, dir_rows[n].fixed, dir_rows[n].result);

        // Random phases, each with its own screen size. The sizes include zero, the largest
        // value that fits the register, and very narrow or very flat screens.
        phase_w = '{0, SIZE_MAX, 1, 4096, 640, 0, RESET_WIDTH};
        phase_h = '{0, SIZE_MAX, 4096, 1, 480, 0, RESET_HEIGHT};
        phase_w[5] = $urandom_range(1, 4096);
        phase_h[5] = $urandom_range(1, 4096);
        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            // The last phase runs with no idling on either side. The others pick at random.
            idle_on = (p == NUM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 4) != 0);
            write_reg(REG_SCREEN_WIDTH, phase_w[p]);
            write_reg(REG_SCREEN_HEIGHT, phase_h[p]);
            // A write to an index beyond the two registers must change nothing.
            write_reg(p[0] ? REG_SPARE_3 : REG_SPARE_2, $urandom_range(0, SIZE_MAX));
            repeat (RANDOM_WORDS) send_word(random_quad(), 1'b0, '0);
        end

        // Wait for the last result words, then watch a little longer for stray ones.
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_bins.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("quad_tile_binning_unit_test OK");
        else
            $display("quad_tile_binning_unit_test NOT OK");
        $finish;
    end

endmodule
